[hdl/owcm_pkg.sv]
// ----------------------------------------------------------------------------
// owcm_pkg: shared types and constants of the omni wheel command mixer
// Message parser codes, queue word type and CORDIC step angles.
// ----------------------------------------------------------------------------
package owcm_pkg;

  localparam int unsigned MsgCapacityDef = 20;
  localparam logic [14:0] SpeedGainRst   = 15'd10;

  localparam logic [15:0] OffsetFl = 16'd43691;
  localparam logic [15:0] OffsetFr = 16'd21845;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_X    = 2'd1,
    KIND_Y    = 2'd2,
    KIND_STOP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    NUM_WAIT = 2'd0,
    NUM_DIG  = 2'd1,
    NUM_DONE = 2'd2
  } num_phase_e;

  // word handed from parser to mixer at message end
  typedef struct packed {
    logic        stop;
    logic        set_x;
    logic        set_y;
    logic [15:0] value;
  } msg_t;

  function automatic logic [15:0] step_angle(input logic [3:0] i);
    logic [15:0] a;
    unique case (i)
      4'd0:  a = 16'd8192;
      4'd1:  a = 16'd4836;
      4'd2:  a = 16'd2555;
      4'd3:  a = 16'd1297;
      4'd4:  a = 16'd651;
      4'd5:  a = 16'd326;
      4'd6:  a = 16'd163;
      4'd7:  a = 16'd81;
      4'd8:  a = 16'd41;
      4'd9:  a = 16'd20;
      4'd10: a = 16'd10;
      4'd11: a = 16'd5;
      4'd12: a = 16'd3;
      4'd13: a = 16'd1;
      4'd14: a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

[hdl/owcm_parser.sv]
// ----------------------------------------------------------------------------
// owcm_parser: message front end
// Takes one character a cycle while the queue is not full, tracks prefix and
// number, and pushes a message word into the queue at message end.
// ----------------------------------------------------------------------------
module owcm_parser import owcm_pkg::*; #(
  parameter int unsigned MsgCapacity = MsgCapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output msg_t       msg_o,
  input  logic       full_i
);

  localparam int unsigned CntW = $clog2(MsgCapacity);
  localparam logic [CntW-1:0] LastCnt = CntW'(MsgCapacity - 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      pfx_q, pfx_d;
  kind_e           kind_q, kind_d;
  num_phase_e      ph_q, ph_d;
  logic            neg_q, neg_d;
  logic [15:0]     acc_q, acc_d;

  logic        take, is_digit, finish;
  logic [19:0] mul;
  logic [15:0] value;

  assign stall_o  = full_i;
  assign take     = valid_i && !full_i;
  assign is_digit = rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39;
  assign mul      = {acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + 20'(rx_byte_i - 8'h30);

  always_comb begin
    cnt_d  = cnt_q;
    pfx_d  = pfx_q;
    kind_d = kind_q;
    ph_d   = ph_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    finish = 1'b0;
    if (take && rx_byte_i != 8'h0A) begin
      if (rx_byte_i == 8'h7C) begin
        finish = 1'b1;
      end else begin
        if (pfx_q == 3'd5) begin
          unique case (ph_q)
            NUM_WAIT: begin
              if (rx_byte_i == 8'h20 || (rx_byte_i >= 8'h09 && rx_byte_i <= 8'h0D)) begin
              end else if (rx_byte_i == 8'h2B) begin
                ph_d = NUM_DIG;
              end else if (rx_byte_i == 8'h2D) begin
                neg_d = 1'b1;
                ph_d  = NUM_DIG;
              end else if (is_digit) begin
                acc_d = 16'(rx_byte_i - 8'h30);
                ph_d  = NUM_DIG;
              end else begin
                ph_d = NUM_DONE;
              end
            end
            NUM_DIG: begin
              if (is_digit) acc_d = (mul > 20'd32768) ? 16'd32768 : mul[15:0];
              else          ph_d  = NUM_DONE;
            end
            default: ;
          endcase
        end else if ({2'b0, pfx_q} == 5'(cnt_q) && pfx_q < 3'd5) begin
          logic ok;
          ok = 1'b0;
          unique case (pfx_q)
            3'd0: ok = rx_byte_i == 8'h4C;
            3'd1: ok = rx_byte_i == 8'h33;
            3'd2: ok = rx_byte_i == 8'h5F;
            3'd3: begin
              ok = rx_byte_i == 8'h78 || rx_byte_i == 8'h79;
              if (ok) kind_d = (rx_byte_i == 8'h78) ? KIND_X : KIND_Y;
            end
            default: ok = rx_byte_i == 8'h3A;
          endcase
          if (ok) pfx_d = pfx_q + 3'd1;
          else begin
            pfx_d  = 3'd7;
            kind_d = (pfx_q == 3'd0 && rx_byte_i == 8'h70) ? KIND_STOP : KIND_NONE;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == LastCnt) finish = 1'b1;
      end
    end
  end

  // build the final message word from the next-state values
  assign value = neg_d ? 16'(-{1'b0, acc_d}) :
                 (acc_d > 16'd32767 ? 16'd32767 : acc_d);

  always_comb begin
    msg_o.stop  = kind_d == KIND_STOP;
    msg_o.set_x = pfx_d == 3'd5 && kind_d == KIND_X;
    msg_o.set_y = pfx_d == 3'd5 && kind_d == KIND_Y;
    msg_o.value = value;
  end
  assign push_o = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pfx_q  <= '0;
      kind_q <= KIND_NONE;
      ph_q   <= NUM_WAIT;
      neg_q  <= 1'b0;
      acc_q  <= '0;
    end else if (finish) begin
      cnt_q  <= '0;
      pfx_q  <= '0;
      kind_q <= KIND_NONE;
      ph_q   <= NUM_WAIT;
      neg_q  <= 1'b0;
      acc_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pfx_q  <= pfx_d;
      kind_q <= kind_d;
      ph_q   <= ph_d;
      neg_q  <= neg_d;
      acc_q  <= acc_d;
    end
  end

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q < LastCnt;
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("count past capacity");

  property p_no_push_full;
    @(posedge clk_i) disable iff (!rst_ni) full_i |-> !push_o;
  endproperty
  a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

  property p_pfx_code;
    @(posedge clk_i) disable iff (!rst_ni) pfx_q <= 3'd5 || pfx_q == 3'd7;
  endproperty
  a_pfx_code: assert property (p_pfx_code) else $error("bad prefix state");

endmodule

[hdl/owcm_queue.sv]
// ----------------------------------------------------------------------------
// owcm_queue: two-entry message queue
// Decouples the parser from the mixer.
// ----------------------------------------------------------------------------
module owcm_queue import owcm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  msg_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output msg_t data_o
);

  msg_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] n_q;

  assign full_o  = n_q == 2'd2;
  assign empty_o = n_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      n_q  <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      n_q <= n_q + 2'(push_i) - 2'(pop_i);
    end
  end

  property p_no_ovf;
    @(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o);
  endproperty
  a_no_ovf: assert property (p_no_ovf) else $error("queue overflow");

  property p_no_unf;
    @(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o);
  endproperty
  a_no_unf: assert property (p_no_unf) else $error("queue underflow");

  property p_level;
    @(posedge clk_i) disable iff (!rst_ni) n_q <= 2'd2;
  endproperty
  a_level: assert property (p_level) else $error("queue level");

endmodule

[hdl/owcm_mixer.sv]
// ----------------------------------------------------------------------------
// owcm_mixer: wheel drive back end
// On stop zeroes the drives; else updates the stick, runs vectoring CORDIC for the
// angle unless at the origin, then rotation CORDIC once per wheel, one iteration a cycle on a shared datapath.
// ----------------------------------------------------------------------------
module owcm_mixer import owcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [14:0] speed_gain_i,
  input  logic        empty_i,
  input  msg_t        msg_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] drive_front_left_o,
  output logic [15:0] drive_front_right_o,
  output logic [15:0] drive_rear_o
);

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_VEC  = 6'b000010,
    ST_ROT  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_STOR = 6'b010000,
    ST_OUT  = 6'b100000
  } st_e;

  st_e st_q, st_d;
  logic signed [15:0] sx_q, sy_q;
  logic signed [33:0] x_q, y_q;
  logic signed [16:0] z_q;
  logic [3:0]  it_q;
  logic [1:0]  wh_q;
  logic [15:0] th_q;
  logic        flip_q;
  logic signed [17:0] c_q;
  logic [15:0] r_q [3];

  logic signed [33:0] dx, dy, nx, ny, xv, yv, cr;
  logic signed [16:0] nz;
  logic               dir;
  logic [15:0] th_sel;
  logic [1:0]  wh_sel;
  logic [15:0] off, p, pf;
  logic        fl;
  logic signed [15:0] nsx, nsy;
  logic signed [33:0] prod;
  logic [33:0] mag;
  logic [15:0] mag_c, drv;

  assign nsx = msg_i.set_x ? msg_i.value : sx_q;
  assign nsy = msg_i.set_y ? msg_i.value : sy_q;
  assign xv  = 34'(nsx) <<< 14;
  assign yv  = 34'(nsy) <<< 14;

  // phase of the wheel whose rotation starts next, folded into a quarter turn
  always_comb begin
    th_sel = th_q;
    wh_sel = wh_q + 2'd1;
    if (st_q == ST_IDLE) begin
      th_sel = '0;
      wh_sel = '0;
    end else if (st_q == ST_VEC) begin
      th_sel = nz[15:0];
      wh_sel = '0;
    end
    unique case (wh_sel)
      2'd0:    off = OffsetFl;
      2'd1:    off = OffsetFr;
      default: off = 16'd0;
    endcase
    p  = th_sel - off;
    fl = p > 16'h4000 && p < 16'hC000;
    pf = fl ? p - 16'h8000 : p;
  end

  assign dx  = y_q >>> it_q;
  assign dy  = x_q >>> it_q;
  assign dir = (st_q == ST_VEC) ? !y_q[33] : !z_q[16];
  always_comb begin
    if ((st_q == ST_VEC) == dir) begin
      nx = x_q + dx;  ny = y_q - dy;
    end else begin
      nx = x_q - dx;  ny = y_q + dy;
    end
    if (st_q == ST_ROT) nz = dir ? z_q - 17'(step_angle(it_q)) : z_q + 17'(step_angle(it_q));
    else                nz = dir ? z_q + 17'(step_angle(it_q)) : z_q - 17'(step_angle(it_q));
  end

  assign cr   = (x_q + 34'sd8192) >>> 14;
  assign prod = $signed({19'b0, speed_gain_i}) * 34'(c_q);
  assign mag  = prod[33] ? 34'(-prod) : prod;
  assign mag_c = (mag[33:16] > 18'd32767) ? 16'd32767 : mag[31:16];
  assign drv   = prod[33] ? 16'(-mag_c) : mag_c;

  assign pop_o   = st_q == ST_IDLE && !empty_i;
  assign valid_o = st_q == ST_OUT;
  assign drive_front_left_o  = r_q[0];
  assign drive_front_right_o = r_q[1];
  assign drive_rear_o        = r_q[2];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (!empty_i) st_d = msg_i.stop ? ST_OUT :
                                     (nsx == 0 && nsy == 0) ? ST_ROT : ST_VEC;
      ST_VEC:  if (it_q == 4'd15) st_d = ST_ROT;
      ST_ROT:  if (it_q == 4'd15) st_d = ST_MUL;
      ST_MUL:  st_d = ST_STOR;
      ST_STOR: st_d = (wh_q == 2'd2) ? ST_OUT : ST_ROT;
      ST_OUT:  if (!stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      sx_q <= '0;
      sy_q <= '0;
    end else begin
      st_q <= st_d;
      if (pop_o && !msg_i.stop) begin
        sx_q <= nsx;
        sy_q <= nsy;
      end
    end
  end

  // datapath: setup for the next CORDIC run is done in idle, at the end of vectoring and in store
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        it_q <= '0;
        wh_q <= '0;
        th_q <= '0;
        if (msg_i.stop) begin
          r_q[0] <= '0; r_q[1] <= '0; r_q[2] <= '0;
        end
        if (nsx == 0 && nsy == 0) begin
          // origin: angle 0, straight into the first wheel's rotation
          x_q <= CordicGain; y_q <= '0; z_q <= 17'($signed(pf)); flip_q <= fl;
        end else if (xv[33]) begin
          x_q <= -xv; y_q <= -yv; z_q <= 17'sh08000;
        end else begin
          x_q <= xv;  y_q <= yv;  z_q <= '0;
        end
      end
      ST_VEC: begin
        it_q <= it_q + 4'd1;
        if (it_q == 4'd15) begin
          th_q   <= nz[15:0];
          x_q    <= CordicGain;
          y_q    <= '0;
          z_q    <= 17'($signed(pf));
          flip_q <= fl;
        end else begin
          x_q <= nx; y_q <= ny; z_q <= nz;
        end
      end
      ST_ROT: begin
        it_q <= it_q + 4'd1;
        x_q <= nx; y_q <= ny; z_q <= nz;
      end
      ST_MUL: begin
        if (flip_q) c_q <= (cr > 34'sd65536) ? -18'sd65536 :
                           (cr < -34'sd65536) ? 18'sd65536 : 18'(-cr);
        else        c_q <= (cr > 34'sd65536) ? 18'sd65536 :
                           (cr < -34'sd65536) ? -18'sd65536 : 18'(cr);
      end
      ST_STOR: begin
        r_q[wh_q] <= drv;
        wh_q   <= wh_q + 2'd1;
        it_q   <= '0;
        x_q    <= CordicGain;
        y_q    <= '0;
        z_q    <= 17'($signed(pf));
        flip_q <= fl;
      end
      default: ;
    endcase
  end

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni) valid_o && stall_i |=> valid_o && $stable(r_q[0]);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  property p_pop_idle;
    @(posedge clk_i) disable iff (!rst_ni) pop_o |-> st_q == ST_IDLE;
  endproperty
  a_pop_idle: assert property (p_pop_idle) else $error("pop while busy");

  property p_onehot;
    @(posedge clk_i) disable iff (!rst_ni) $onehot(st_q);
  endproperty
  a_onehot: assert property (p_onehot) else $error("state not one-hot");

endmodule

[hdl/omni_wheel_command_mixer.sv]
// ----------------------------------------------------------------------------
// omni_wheel_command_mixer: three-wheel omni drive mixer
// Parses stick messages from serial text and emits three wheel drives.
//
//   port group      dir  handshake        payload
//   rx              in   rx_valid_i/stall  rx_byte_i
//   drive           out  drv_valid_o/stall drive_front_left/right, rear
//   speed_gain      in   speed_gain_we_i   speed_gain_i
//
// A message end holds the mixer for a pop, the vectoring run, then for each
// wheel a rotation run, a multiply and a store, and an output state, plus
// any output stall; at the origin the vectoring run is skipped, and a stop
// message goes from the pop straight to output. One shared CORDIC datapath.
// A two-word queue lets the parser run on while the mixer works; rx stalls
// only when that queue is full. No clearing pass at reset.
// ----------------------------------------------------------------------------
module omni_wheel_command_mixer import owcm_pkg::*; #(
  parameter int unsigned MsgCapacity = MsgCapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        speed_gain_we_i,
  input  logic [14:0] speed_gain_i,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        drv_valid_o,
  input  logic        drv_stall_i,
  output logic [15:0] drive_front_left_o,
  output logic [15:0] drive_front_right_o,
  output logic [15:0] drive_rear_o
);

  logic [14:0] gain_q;
  logic push, full, pop, empty;
  msg_t qin, qout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gain_q <= SpeedGainRst;
    else if (speed_gain_we_i) gain_q <= speed_gain_i;
  end

  owcm_parser #(.MsgCapacity(MsgCapacity)) u_parser (
    .clk_i, .rst_ni, .valid_i(rx_valid_i), .stall_o(rx_stall_o), .rx_byte_i,
    .push_o(push), .msg_o(qin), .full_i(full)
  );

  owcm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(qin), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qout)
  );

  owcm_mixer u_mixer (
    .clk_i, .rst_ni, .speed_gain_i(gain_q), .empty_i(empty), .msg_i(qout),
    .pop_o(pop), .valid_o(drv_valid_o), .stall_i(drv_stall_i),
    .drive_front_left_o, .drive_front_right_o, .drive_rear_o
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the omni wheel command mixer
// Feeds serial text (stick messages, stop and junk messages, newlines and
// capacity overruns) and compares every drive word against a local CORDIC
// model of the parser and mixer. Random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb;
  import owcm_pkg::*;

  localparam int unsigned MsgCap   = MsgCapacityDef;
  localparam int unsigned WdogMax  = 20000;
  localparam int unsigned DrainCyc = 300;

  typedef struct packed {
    logic [15:0] fl;
    logic [15:0] fr;
    logic [15:0] rear;
  } drives_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        speed_gain_we_i = 1'b0;
  logic [14:0] speed_gain_i = '0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        drv_valid_o;
  logic        drv_stall_i = 1'b0;
  logic [15:0] drive_front_left_o;
  logic [15:0] drive_front_right_o;
  logic [15:0] drive_rear_o;

  omni_wheel_command_mixer i_dut (
    .clk_i, .rst_ni, .speed_gain_we_i, .speed_gain_i,
    .rx_valid_i, .rx_stall_o, .rx_byte_i,
    .drv_valid_o, .drv_stall_i,
    .drive_front_left_o, .drive_front_right_o, .drive_rear_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // model state
  int unsigned  m_gain;
  int unsigned  m_count;
  int unsigned  m_prefix;
  kind_e        m_kind;
  num_phase_e   m_phase;
  bit           m_neg;
  int unsigned  m_accum;
  int           m_sx;
  int           m_sy;

  drives_t      drives_due[$];
  logic [7:0]   tx_bytes[$];
  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  int unsigned  words_seen = 0;
  int unsigned  wdog = 0;
  int unsigned  stall_left = 0;
  bit           stall_rand = 1'b1;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int unsigned stick_phase(int sx, int sy);
    longint x, y, dx, dy;
    int z;
    x = longint'(sx) * 16384;
    y = longint'(sy) * 16384;
    z = 0;
    if (sx == 0 && sy == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32768;
    end
    for (int i = 0; i < 16; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += int'(step_angle(i[3:0]));
      end else begin
        x -= dx; y += dy; z -= int'(step_angle(i[3:0]));
      end
    end
    return z & 16'hFFFF;
  endfunction

  function automatic logic [15:0] wheel(int unsigned th, int unsigned off);
    int unsigned p;
    bit flip;
    int z;
    longint x, y, dx, dy, c, prod, mag;
    p = (th - off) & 16'hFFFF;
    flip = 1'b0;
    x = 64'd652032874;
    y = 0;
    if (p > 16'h4000 && p < 16'hC000) begin
      p = (p - 16'h8000) & 16'hFFFF;
      flip = 1'b1;
    end
    z = (p >= 16'h8000) ? int'(p) - 65536 : int'(p);
    for (int i = 0; i < 16; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= int'(step_angle(i[3:0]));
      end else begin
        x += dx; y -= dy; z += int'(step_angle(i[3:0]));
      end
    end
    c = fshr(x + 8192, 14);
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    if (flip) c = -c;
    prod = longint'(m_gain) * c;
    mag = (prod < 0) ? -prod : prod;
    mag = mag >> 16;
    if (mag > 32767) mag = 32767;
    return (prod < 0) ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic void clear_msg();
    m_count = 0; m_prefix = 0; m_kind = KIND_NONE;
    m_phase = NUM_WAIT; m_neg = 1'b0; m_accum = 0;
  endfunction

  function automatic void close_msg();
    int v;
    int unsigned th;
    drives_t d;
    if (m_kind == KIND_STOP) begin
      d = '0;
    end else begin
      if (m_prefix == 5) begin
        v = m_neg ? -int'(m_accum) : (m_accum > 32767 ? 32767 : int'(m_accum));
        if (m_kind == KIND_X) m_sx = v;
        else if (m_kind == KIND_Y) m_sy = v;
      end
      th = stick_phase(m_sx, m_sy);
      d.fl = wheel(th, OffsetFl);
      d.fr = wheel(th, OffsetFr);
      d.rear = wheel(th, 0);
    end
    drives_due.push_back(d);
    clear_msg();
  endfunction

  function automatic void parse_char(logic [7:0] c);
    bit digit, ok;
    digit = (c >= "0" && c <= "9");
    if (m_prefix == 5) begin
      if (m_phase == NUM_WAIT) begin
        if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D) begin
        end else if (c == "+") m_phase = NUM_DIG;
        else if (c == "-") begin
          m_neg = 1'b1; m_phase = NUM_DIG;
        end else if (digit) begin
          m_accum = c - "0"; m_phase = NUM_DIG;
        end else m_phase = NUM_DONE;
      end else if (m_phase == NUM_DIG) begin
        if (digit) begin
          m_accum = m_accum * 10 + (c - "0");
          if (m_accum > 32768) m_accum = 32768;
        end else m_phase = NUM_DONE;
      end
      return;
    end
    if (m_prefix == m_count && m_count < 5) begin
      case (m_count)
        0: ok = (c == "L");
        1: ok = (c == "3");
        2: ok = (c == "_");
        3: begin
          ok = (c == "x" || c == "y");
          if (ok) m_kind = (c == "x") ? KIND_X : KIND_Y;
        end
        default: ok = (c == ":");
      endcase
      if (ok) m_prefix++;
      else begin
        m_prefix = 7;
        m_kind = (m_count == 0 && c == "p") ? KIND_STOP : KIND_NONE;
      end
    end
  endfunction

  function automatic void model_byte(logic [7:0] c);
    if (c == 8'h0A) return;
    if (c == "|") begin
      close_msg();
      return;
    end
    if (m_count < MsgCap - 1) begin
      parse_char(c);
      m_count = (m_count + 1) & 31;
    end
    if (m_count >= MsgCap - 1) close_msg();
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 45) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  function automatic void push_stick();
    string s;
    int unsigned n;
    s = ($urandom_range(0, 1) != 0) ? "L3_x:" : "L3_y:";
    if ($urandom_range(0, 5) == 0) s = {s, " "};
    case ($urandom_range(0, 3))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    if ($urandom_range(0, 4) == 0) s = {s, "ab7"};
    if ($urandom_range(0, 7) == 0) s = {s, "\n"};
    push_str(s);
    if ($urandom_range(0, 9) != 0) tx_bytes.push_back("|");
  endfunction

  // sender
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && !rx_stall_o) begin
        model_byte(rx_byte_i);
        words_sent++;
      end
      if (!rx_valid_i || !rx_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          rx_valid_i <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          rx_byte_i <= tx_bytes.pop_front();
          rx_valid_i <= 1'b1;
          gap_left <= gap_len();
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t drive %0d %s: got %0d want %0d", $realtime, words_seen, what,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  // receiver
  always @(posedge clk_i) begin
    drives_t d;
    if (rst_ni) begin
      if (drv_valid_o && !drv_stall_i) begin
        if (drives_due.size() == 0) begin
          report_mismatch("unexpected", drive_rear_o, 16'd0);
        end else begin
          d = drives_due.pop_front();
          if (drive_front_left_o !== d.fl) report_mismatch("fl", drive_front_left_o, d.fl);
          if (drive_front_right_o !== d.fr)
            report_mismatch("fr", drive_front_right_o, d.fr);
          if (drive_rear_o !== d.rear) report_mismatch("rear", drive_rear_o, d.rear);
        end
        words_seen++;
      end
      // stall runs: mostly short, a few long
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        drv_stall_i <= 1'b1;
      end else if (stall_rand && $urandom_range(0, 99) < 30) begin
        stall_left <= gap_len();
        drv_stall_i <= 1'b1;
      end else begin
        drv_stall_i <= 1'b0;
      end
      if ((rx_valid_i && !rx_stall_o) || (drv_valid_o && !drv_stall_i)) wdog <= 0;
      else if (tx_bytes.size() != 0 || drives_due.size() != 0 || rx_valid_i) begin
        wdog <= wdog + 1;
      end
      if (wdog >= WdogMax) begin
        $display("watchdog expired, %0d drives outstanding", drives_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic drain();
    while (tx_bytes.size() != 0 || rx_valid_i || drives_due.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  task automatic set_gain(logic [14:0] g);
    drain();
    speed_gain_i <= g;
    speed_gain_we_i <= 1'b1;
    @(posedge clk_i);
    speed_gain_we_i <= 1'b0;
    m_gain = g;
  endtask

  initial begin
    logic [14:0] gains[4];
    m_gain = SpeedGainRst;
    m_sx = 0;
    m_sy = 0;
    clear_msg();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset gain first, lone end, stop, overrun, extremes
    push_str("|L3_x:99999|L3_y:-99999|pq|\nL3_x:-0|L3_y:0|");
    push_str("L3_x:32767|xyzxyzxyzxyzxyzxyzxyz");
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back("|");
    set_gain(15'd32767);
    push_str("L3_y:\t-32768|L3_x:0|L3_y:7 1|");
    set_gain(15'd0);
    push_str("L3_x:-5|");
    gains = '{15'd1, 15'd10, 15'd32767, 15'd12345};
    for (int ph = 0; ph < 4; ph++) begin
      set_gain(ph == 3 ? 15'($urandom) : gains[ph]);
      stall_rand = (ph != 1);
      for (int k = 0; k < 32; k++) begin
        case ($urandom_range(0, 9))
          0: push_str("p|");
          1: for (int j = 0; j < 6; j++) tx_bytes.push_back(8'($urandom));
          default: push_stick();
        endcase
      end
    end
    drain();
    $display("run covered %0d serial words and %0d drive words over several gain settings",
             words_sent, words_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
